// ----- src/decimal_command_frame_parser_defines.svh -----
// Assertion macros shared by the parser RTL.
// All checks are sampled on clk and disabled while rst_n is low.
`ifndef DECIMAL_COMMAND_FRAME_PARSER_DEFINES_SVH
`define DECIMAL_COMMAND_FRAME_PARSER_DEFINES_SVH

// Condition must hold at every clock edge.
`define DCFP_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define DCFP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- src/dcfp_pkg.sv -----
package dcfp_pkg;

    // Frame delimiters and digit offset (ASCII)
    localparam logic [7:0] CH_START = 8'h3A;
    localparam logic [7:0] CH_END   = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // Position of the closing '#' in a well-formed frame
    localparam int FRAME_LAST = 22;

    // Default store depth (saturation point of the position counter)
    localparam int STORE_DEPTH_DEF = 24;

    // Frame positions 1..21 are kept; position 0 is the colon
    localparam int TAP_COUNT = 21;

    localparam logic [15:0] HOLD_RESET = 16'd1500;
    localparam logic [7:0]  AUX_RESET  = 8'd0;

    typedef logic [7:0]  digit_t;
    typedef logic [15:0] channel_t;

    // taps[0] is the most recently stored byte
    typedef digit_t [TAP_COUNT-1:0] tap_line_t;

    // Four-digit decimal value, modulo 2^16
    function automatic channel_t four_digits(digit_t d3, digit_t d2, digit_t d1, digit_t d0);
        channel_t sum;
        sum = channel_t'(d3) * 16'd1000
            + channel_t'(d2) * 16'd100
            + channel_t'(d1) * 16'd10
            + channel_t'(d0);
        return sum;
    endfunction

endpackage

// ----- src/dcfp_collector.sv -----
module dcfp_collector #(
    parameter int STORE_DEPTH = dcfp_pkg::STORE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  dcfp_pkg::digit_t   rx_byte,
    output dcfp_pkg::tap_line_t taps,
    output logic               frame_ok
);
    import dcfp_pkg::*;

    localparam int PosW = $clog2(STORE_DEPTH + 1);

    logic            collecting_reg, collecting_next;
    logic [PosW-1:0] position_reg, position_next;
    tap_line_t       taps_reg;

    logic            start;
    logic            col_eff;
    logic [PosW-1:0] pos_eff;
    logic            stored;
    logic            is_end;

    // Frame tracking for the byte in the input register
    always_comb
    begin
        start    = (rx_byte == CH_START) && !collecting_reg;
        col_eff  = collecting_reg || start;
        pos_eff  = start ? '0 : position_reg;
        stored   = col_eff && (pos_eff < PosW'(STORE_DEPTH));
        is_end   = col_eff && (rx_byte == CH_END);
        frame_ok = is_end && stored && (pos_eff == PosW'(FRAME_LAST));
    end

    // Next state: '#' always returns to idle; overlong frames saturate
    always_comb
    begin
        collecting_next = collecting_reg;
        position_next   = position_reg;
        if (fire)
        begin
            if (is_end)
            begin
                collecting_next = 1'b0;
                position_next   = '0;
            end
            else if (col_eff)
            begin
                collecting_next = 1'b1;
                position_next   = stored ? pos_eff + PosW'(1) : PosW'(STORE_DEPTH);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            collecting_reg <= 1'b0;
            position_reg   <= '0;
        end
        else
        begin
            collecting_reg <= collecting_next;
            position_reg   <= position_next;
        end
    end

    // Shift line of stored bytes; an accepted frame always refills all taps
    always_ff @(posedge clk)
    begin
        if (fire && stored)
        begin
            taps_reg <= {taps_reg[TAP_COUNT-2:0], digit_t'(rx_byte - CH_ZERO)};
        end
    end

    assign taps = taps_reg;

    `include "decimal_command_frame_parser_defines.svh"

    `DCFP_ASSERT_HOLDS(a_pos_bound, position_reg <= PosW'(STORE_DEPTH), "position beyond store")
    `DCFP_ASSERT_IMPLIES(a_idle_pos, !collecting_reg, position_reg == '0, "idle with nonzero position")

endmodule

// ----- src/dcfp_decoder.sv -----
module dcfp_decoder (
    input  dcfp_pkg::tap_line_t taps,
    output dcfp_pkg::channel_t  value_one,
    output dcfp_pkg::channel_t  value_two,
    output dcfp_pkg::channel_t  value_three,
    output dcfp_pkg::channel_t  value_four,
    output dcfp_pkg::digit_t    value_aux
);
    import dcfp_pkg::*;

    // Frame position p sits at taps[21 - p] when the '#' arrives
    always_comb
    begin
        value_one   = four_digits(taps[20], taps[19], taps[18], taps[17]);
        value_two   = four_digits(taps[15], taps[14], taps[13], taps[12]);
        value_three = four_digits(taps[10], taps[9],  taps[8],  taps[7]);
        value_four  = four_digits(taps[5],  taps[4],  taps[3],  taps[2]);
        value_aux   = taps[0];
    end

endmodule

// ----- src/decimal_command_frame_parser.sv -----
// Decimal command frame parser: takes one received byte per transfer and parses frames of the
// form ":dddd,dddd,dddd,dddd,d#" (23 bytes, separators not checked). A new byte is taken every
// clock while in_stall is low; each byte yields one result via an input register and a result
// register, and the result holds the four channel values and the aux digit as last accepted,
// plus frame_accepted high for the byte that closed a valid frame. Channels reset to 1500, aux
// to 0. Digits are taken as byte minus '0' with 8-bit wrap and channels wrap modulo 2^16.
// Frames longer than STORE_DEPTH bytes, or of any length other than 23, are dropped at the '#'.
module decimal_command_frame_parser #(
    parameter int STORE_DEPTH = dcfp_pkg::STORE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  dcfp_pkg::digit_t   rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output dcfp_pkg::channel_t channel_one,
    output dcfp_pkg::channel_t channel_two,
    output dcfp_pkg::channel_t channel_three,
    output dcfp_pkg::channel_t channel_four,
    output dcfp_pkg::digit_t   aux_value,
    output logic               frame_accepted
);
    import dcfp_pkg::*;

    logic      s1_valid_reg, s1_valid_next;
    digit_t    s1_byte_reg;
    logic      out_valid_reg, out_valid_next;
    channel_t  ch_one_reg, ch_two_reg, ch_three_reg, ch_four_reg;
    digit_t    aux_reg;
    logic      accepted_reg;

    logic      advance;
    logic      fire;
    logic      frame_ok;
    tap_line_t taps;
    channel_t  value_one, value_two, value_three, value_four;
    digit_t    value_aux;

    // Handshake: the input register moves on whenever the result register frees up
    always_comb
    begin
        advance        = !out_valid_reg || !out_stall;
        fire           = s1_valid_reg && advance;
        in_stall       = s1_valid_reg && !advance;
        s1_valid_next  = (in_valid && !in_stall) || (s1_valid_reg && !fire);
        out_valid_next = fire || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    dcfp_collector #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_collector (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .rx_byte  (s1_byte_reg),
        .taps     (taps),
        .frame_ok (frame_ok)
    );

    dcfp_decoder u_decoder (
        .taps        (taps),
        .value_one   (value_one),
        .value_two   (value_two),
        .value_three (value_three),
        .value_four  (value_four),
        .value_aux   (value_aux)
    );

    // Held values double as the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_one_reg   <= HOLD_RESET;
            ch_two_reg   <= HOLD_RESET;
            ch_three_reg <= HOLD_RESET;
            ch_four_reg  <= HOLD_RESET;
            aux_reg      <= AUX_RESET;
            accepted_reg <= 1'b0;
        end
        else if (fire)
        begin
            accepted_reg <= frame_ok;
            if (frame_ok)
            begin
                ch_one_reg   <= value_one;
                ch_two_reg   <= value_two;
                ch_three_reg <= value_three;
                ch_four_reg  <= value_four;
                aux_reg      <= value_aux;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign channel_one    = ch_one_reg;
    assign channel_two    = ch_two_reg;
    assign channel_three  = ch_three_reg;
    assign channel_four   = ch_four_reg;
    assign aux_value      = aux_reg;
    assign frame_accepted = accepted_reg;

    `include "decimal_command_frame_parser_defines.svh"

    `DCFP_ASSERT_IMPLIES(a_free_no_stall, !s1_valid_reg || !out_valid_reg, !in_stall, "stall while room")
    `DCFP_ASSERT_IMPLIES(a_hold_on_accept, !$stable(ch_one_reg), accepted_reg, "held value moved without accept")
    `DCFP_ASSERT_IMPLIES(a_accept_valid, accepted_reg && $rose(accepted_reg), out_valid_reg, "accept flag without result")

endmodule

// ----- tb/sv/decimal_command_frame_parser_test.sv -----
module decimal_command_frame_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dcfp_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int BYTE_TARGET = 700;
    localparam int DRAIN_CYCLES = 8;
    localparam int SHOWN_ERRORS = 10;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NINE = 8'h39;

    typedef enum {
        FILL_NINE,
        FILL_ZERO,
        FILL_MAX,
        FILL_MIN,
        FILL_COLON,
        FILL_DIGIT,
        FILL_ANY
    } fill_kind_t;

    typedef struct packed {
        channel_t channel_one;
        channel_t channel_two;
        channel_t channel_three;
        channel_t channel_four;
        digit_t   aux_value;
        logic     frame_accepted;
    } parser_view_t;

    logic     clk;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    digit_t   rx_byte = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    channel_t channel_one;
    channel_t channel_two;
    channel_t channel_three;
    channel_t channel_four;
    digit_t   aux_value;
    logic     frame_accepted;

    decimal_command_frame_parser uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .channel_one    (channel_one),
        .channel_two    (channel_two),
        .channel_three  (channel_three),
        .channel_four   (channel_four),
        .aux_value      (aux_value),
        .frame_accepted (frame_accepted)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Bytes waiting to be sent, and parser views waiting to come back
    digit_t       pending_bytes[$];
    parser_view_t expected_views[$];

    int framed_bytes = 0;
    int bytes_sent = 0;
    int results_checked = 0;
    int frames_taken = 0;
    int frames_dropped = 0;
    int error_count = 0;

    // Parser shadow state
    logic     shadow_collecting = 1'b0;
    int       shadow_position = 0;
    digit_t   shadow_store[STORE_DEPTH_DEF];
    channel_t shadow_channels[4] = '{HOLD_RESET, HOLD_RESET, HOLD_RESET, HOLD_RESET};
    digit_t   shadow_aux = AUX_RESET;

    initial
    begin
        foreach (shadow_store[i])
            shadow_store[i] = '0;
    end

    // Decimal value of four stored digits starting at a frame position, mod 2^16
    function automatic channel_t decimal_word(int first);
        logic [31:0] acc;
        acc = 32'(shadow_store[first]) * 1000
            + 32'(shadow_store[first + 1]) * 100
            + 32'(shadow_store[first + 2]) * 10
            + 32'(shadow_store[first + 3]);
        return acc[15:0];
    endfunction

    // Advance the shadow parser by one byte and queue the view it produces
    task automatic advance_parser(digit_t b);
        logic         stored;
        int           prior;
        parser_view_t view;
        stored = 1'b0;
        prior = shadow_position;
        view.frame_accepted = 1'b0;
        if (b == CH_START && !shadow_collecting)
        begin
            shadow_position = 0;
            shadow_collecting = 1'b1;
            prior = 0;
        end
        if (shadow_collecting)
        begin
            if (shadow_position < STORE_DEPTH_DEF)
            begin
                shadow_store[shadow_position] = b - CH_ZERO;
                shadow_position++;
                stored = 1'b1;
            end
            else
                shadow_position = STORE_DEPTH_DEF;
            if (b == CH_END)
            begin
                if (stored && prior == FRAME_LAST)
                begin
                    shadow_channels[0] = decimal_word(1);
                    shadow_channels[1] = decimal_word(6);
                    shadow_channels[2] = decimal_word(11);
                    shadow_channels[3] = decimal_word(16);
                    shadow_aux = shadow_store[21];
                    view.frame_accepted = 1'b1;
                    frames_taken++;
                end
                else
                    frames_dropped++;
                foreach (shadow_store[i])
                    shadow_store[i] = '0;
                shadow_position = 0;
                shadow_collecting = 1'b0;
            end
        end
        view.channel_one = shadow_channels[0];
        view.channel_two = shadow_channels[1];
        view.channel_three = shadow_channels[2];
        view.channel_four = shadow_channels[3];
        view.aux_value = shadow_aux;
        expected_views.push_back(view);
    endtask

    function automatic digit_t fill_byte(fill_kind_t fill);
        digit_t b;
        case (fill)
            FILL_NINE:  b = CH_NINE;
            FILL_ZERO:  b = CH_ZERO;
            FILL_MAX:   b = 8'hFF;
            FILL_MIN:   b = 8'h00;
            FILL_COLON: b = CH_START;
            FILL_DIGIT: b = CH_ZERO + digit_t'($urandom_range(0, 9));
            default:
            begin
                // any byte, but a '#' would end the frame early
                do
                    b = digit_t'($urandom_range(0, 255));
                while (b == CH_END);
            end
        endcase
        return b;
    endfunction

    // ':' + body + '#'; a body of 21 bytes makes a well-formed frame
    task automatic push_frame(int body_len, fill_kind_t fill);
        int pos;
        pending_bytes.push_back(CH_START);
        for (int i = 0; i < body_len; i++)
        begin
            pos = i + 1;
            if (fill != FILL_ANY && (pos == 5 || pos == 10 || pos == 15 || pos == 20))
                pending_bytes.push_back(CH_COMMA);
            else
                pending_bytes.push_back(fill_byte(fill));
        end
        pending_bytes.push_back(CH_END);
        framed_bytes += body_len + 2;
    endtask

    // Stimulus
    initial
    begin
        int pick;
        int len;

        // bytes while idle are ignored, '#' included
        pending_bytes.push_back(CH_END);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'h41);
        // digit extremes, byte wrap, and a colon stored mid-frame
        push_frame(21, FILL_NINE);
        push_frame(21, FILL_ZERO);
        push_frame(21, FILL_MAX);
        push_frame(21, FILL_MIN);
        push_frame(21, FILL_COLON);
        // wrong lengths: short, one too long, '#' past the store, overlong, empty
        push_frame(20, FILL_DIGIT);
        push_frame(22, FILL_DIGIT);
        push_frame(23, FILL_DIGIT);
        push_frame(30, FILL_DIGIT);
        push_frame(0, FILL_DIGIT);

        // mostly good frames with random content, some broken ones and noise
        while (framed_bytes < BYTE_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                push_frame(21, FILL_DIGIT);
            else if (pick < 72)
                push_frame(21, FILL_ANY);
            else if (pick < 84)
            begin
                len = $urandom_range(0, 24);
                if (len == 21)
                    len = 20;
                push_frame(len, ($urandom_range(0, 1) == 0) ? FILL_DIGIT : FILL_ANY);
            end
            else if (pick < 90)
                push_frame($urandom_range(23, 40), FILL_DIGIT);
            else
                repeat ($urandom_range(1, 4))
                    pending_bytes.push_back(digit_t'($urandom_range(0, 255)));
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drain
        do
            @(negedge clk);
        while (pending_bytes.size() != 0 || in_valid);
        do
            @(negedge clk);
        while (expected_views.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d bytes, checked %0d results", bytes_sent, results_checked);
        $display("Frames: %0d accepted, %0d dropped", frames_taken, frames_dropped);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Sender: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte <= '0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                advance_parser(rx_byte);
                bytes_sent++;
            end
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_bytes.size() != 0)
            begin
                in_valid <= 1'b1;
                rx_byte <= pending_bytes.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end
                else
                    burst_left--;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: stall following a 16-bit pattern word, redrawn each time it runs out
    logic [15:0] stall_word = '0;
    int          stall_phase = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (stall_phase == 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: stall_word = '0;
                    3:       stall_word = 16'($urandom | $urandom);
                    default: stall_word = 16'($urandom & $urandom);
                endcase
            end
            out_stall <= stall_word[stall_phase];
            stall_phase = (stall_phase + 1) % 16;
        end
    end

    function automatic string view_text(parser_view_t v);
        return $sformatf("ch %0d %0d %0d %0d aux %0d acc %0b", v.channel_one,
            v.channel_two, v.channel_three, v.channel_four, v.aux_value, v.frame_accepted);
    endfunction

    // Result checking
    always @(posedge clk)
    begin
        parser_view_t seen;
        parser_view_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen = {channel_one, channel_two, channel_three, channel_four,
                    aux_value, frame_accepted};
            if (expected_views.size() == 0)
            begin
                error_count++;
                if (error_count <= SHOWN_ERRORS)
                    $display("%0t: result with nothing pending: %s", $realtime, view_text(seen));
            end
            else
            begin
                want = expected_views.pop_front();
                results_checked++;
                if (seen !== want)
                begin
                    error_count++;
                    if (error_count <= SHOWN_ERRORS)
                        $display("%0t: result %0d mismatch: expected %s, got %s", $realtime,
                            results_checked, view_text(want), view_text(seen));
                end
            end
        end
    end

    // Watchdog: cycles without a transfer on either side
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout after %0d idle cycles, %0d results pending", idle_cycles,
                    expected_views.size());
                $display("FAIL");
                $finish;
            end
        end
    end

endmodule
